>>> rtl/sbss_pkg.sv
// Package for the stepper batch step scheduler: widths, constants, command codes.
// No dependencies; imported by the channel interfaces and the top level.

package sbss_pkg;

    localparam int unsigned NCH = 4;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned STEPS_W = 31;
    localparam int unsigned JIT_W   = 16;
    localparam int unsigned CMP_W   = 8;

    typedef logic [TIME_W-1:0]  t_time;
    typedef logic [STEPS_W-1:0] t_steps;
    typedef logic signed [TIME_W-1:0] t_pos;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_STAGE   = 2'd1,
        CMD_PUBLISH = 2'd2,
        CMD_SETPOS  = 2'd3
    } t_cmd;

    localparam t_time              LOOKAHEAD_US = t_time'(1000);
    localparam t_time              CMP_WINDOW   = t_time'(512);
    localparam logic [CMP_W-1:0]   CMP_IDLE     = 8'hFF;
    localparam logic [JIT_W-1:0]   JITTER_RESET = 16'd100;

endpackage

>>> rtl/sbss_if.sv
// Channel interfaces of the stepper batch step scheduler: command in, result out,
// jitter register write. Depends on sbss_pkg.

interface sbss_in_if import sbss_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       cmd;
    logic [1:0]       channel;
    t_steps           step_count;
    logic             shorten;
    t_time            interval_us;
    t_pos             position;
    t_time            now_us;

    modport source (output valid, cmd, channel, step_count, shorten, interval_us,
                    position, now_us, input ready);
    modport sink   (input valid, cmd, channel, step_count, shorten, interval_us,
                    position, now_us, output ready);
endinterface

interface sbss_out_if import sbss_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [NCH-1:0]   step_pulses;
    logic [NCH-1:0]   lengthen_dirs;
    logic             has_work;
    logic             batch_pending;
    logic [CMP_W-1:0] compare_value;
    t_pos             cable0;
    t_pos             cable1;
    t_pos             cable2;
    t_pos             cable3;
    logic             rejected;

    modport source (output valid, step_pulses, lengthen_dirs, has_work, batch_pending,
                    compare_value, cable0, cable1, cable2, cable3, rejected,
                    input ready);
    modport sink   (input valid, step_pulses, lengthen_dirs, has_work, batch_pending,
                    compare_value, cable0, cable1, cable2, cable3, rejected,
                    output ready);
endinterface

interface sbss_cfg_if import sbss_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [JIT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> rtl/stepper_batch_step_scheduler.sv
// Top level of the four-channel stepper batch step scheduler.
// Depends on sbss_pkg and the channel interfaces in sbss_if.sv.
//
//  channel | dir | handshake          | carries
//  --------+-----+--------------------+-----------------------------------------
//  i_in    | in  | valid/ready        | cmd, channel, step batch, position, now
//  o_res   | out | valid/ready        | pulses, directions, status, cable positions
//  i_cfg   | in  | valid/ready        | jitter_us write data (always ready)
//
// One transaction is taken every cycle unless the result port stalls. A command waits in
// the input register; the whole tick (batch load, four channel updates, earliest-event
// minimum, compare value) is worked out from it and captured in the result register.
// A stalled result holds the result register and the scheduler state; an occupied input
// register then holds too, so i_in.ready follows o_res.ready in the same cycle.
// Synchronous active-low reset restores start state (jitter 100, compare 255), empties both.

module stepper_batch_step_scheduler
    import sbss_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    sbss_in_if.sink    i_in,
    sbss_out_if.source o_res,
    sbss_cfg_if.sink   i_cfg
);

    // ---------------------------------------------------------------- input register
    logic           r_in_valid;
    t_cmd           r_in_cmd;
    logic [1:0]     r_in_channel;
    t_steps         r_in_steps;
    logic           r_in_shorten;
    t_time          r_in_interval;
    t_pos           r_in_position;
    t_time          r_in_now;

    // ---------------------------------------------------------------- scheduler state
    logic [JIT_W-1:0] r_jitter;
    t_steps           r_rem     [NCH];
    logic [NCH-1:0]   r_shb;
    t_time            r_ivl     [NCH];
    t_time            r_due     [NCH];
    t_steps           r_stg_steps [NCH];
    logic [NCH-1:0]   r_stg_shb;
    t_time            r_stg_ivl [NCH];
    logic             r_staged_ready;
    t_pos             r_cable   [NCH];
    logic             r_work;
    logic [CMP_W-1:0] r_cmp;

    t_steps           n_rem     [NCH];
    logic [NCH-1:0]   n_shb;
    t_time            n_ivl     [NCH];
    t_time            n_due     [NCH];
    t_steps           n_stg_steps [NCH];
    logic [NCH-1:0]   n_stg_shb;
    t_time            n_stg_ivl [NCH];
    logic             n_staged_ready;
    t_pos             n_cable   [NCH];
    logic             n_work;
    logic [CMP_W-1:0] n_cmp;
    logic [NCH-1:0]   n_pulses;
    logic             n_rej;

    // ---------------------------------------------------------------- result register
    logic             r_out_valid;
    logic [NCH-1:0]   r_out_pulses;
    logic             r_out_rej;

    // ---------------------------------------------------------------- tick datapath
    logic             advance;
    logic             any_left;
    logic             load;
    t_steps           rem_l [NCH];
    t_time            due_l [NCH];
    logic [NCH-1:0]   fire;
    t_time            earliest;
    t_time            togo;

    // Move the input register on when the result register is free or being emptied.
    assign advance    = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        any_left = 1'b0;
        for (int i = 0; i < NCH; i++) begin
            any_left = any_left || (r_rem[i] != '0);
        end
    end

    always_comb begin
        n_rem          = r_rem;
        n_shb          = r_shb;
        n_ivl          = r_ivl;
        n_due          = r_due;
        n_stg_steps    = r_stg_steps;
        n_stg_shb      = r_stg_shb;
        n_stg_ivl      = r_stg_ivl;
        n_staged_ready = r_staged_ready;
        n_cable        = r_cable;
        n_work         = r_work;
        n_cmp          = r_cmp;
        n_pulses       = '0;
        n_rej          = 1'b0;
        load           = 1'b0;
        fire           = '0;
        earliest       = r_in_now + LOOKAHEAD_US;
        togo           = '0;
        for (int i = 0; i < NCH; i++) begin
            rem_l[i] = r_rem[i];
            due_l[i] = r_due[i];
        end

        unique case (r_in_cmd)
            CMD_TICK: begin
                if (!any_left && !r_staged_ready) begin
                    // Idle: drop the work flag, keep everything else.
                    n_work = 1'b0;
                end else begin
                    // Load a pending batch once every channel has finished.
                    load = !any_left;
                    if (load) begin
                        n_staged_ready = 1'b0;
                        n_shb          = r_stg_shb;
                        n_ivl          = r_stg_ivl;
                    end
                    for (int i = 0; i < NCH; i++) begin
                        if (load) begin
                            rem_l[i] = r_stg_steps[i];
                            due_l[i] = (r_in_now > r_due[i]) ? r_in_now : r_due[i];
                        end
                        fire[i] = (rem_l[i] != '0) &&
                                  (r_in_now >= (due_l[i] - t_time'(r_jitter)));
                        if (fire[i]) begin
                            n_cable[i] = r_cable[i] + (n_shb[i] ? -32'sd1 : 32'sd1);
                            n_rem[i]   = rem_l[i] - t_steps'(1);
                            n_due[i]   = due_l[i] + n_ivl[i];
                        end else begin
                            n_rem[i]   = rem_l[i];
                            n_due[i]   = due_l[i];
                        end
                        if (n_due[i] < earliest) begin
                            earliest = n_due[i];
                        end
                    end
                    n_pulses = fire;
                    n_work   = n_staged_ready;
                    for (int i = 0; i < NCH; i++) begin
                        n_work = n_work || (n_rem[i] != '0);
                    end
                    togo  = earliest - r_in_now;
                    n_cmp = (togo < CMP_WINDOW) ? togo[CMP_W:1] : CMP_IDLE;
                end
            end
            CMD_STAGE: begin
                if (r_staged_ready) begin
                    n_rej = 1'b1;
                end else begin
                    n_stg_steps[r_in_channel] = r_in_steps;
                    n_stg_shb[r_in_channel]   = r_in_shorten;
                    n_stg_ivl[r_in_channel]   = r_in_interval;
                end
            end
            CMD_PUBLISH: begin
                if (r_staged_ready) begin
                    n_rej = 1'b1;
                end else begin
                    n_staged_ready = 1'b1;
                end
            end
            CMD_SETPOS: begin
                if (r_work || r_staged_ready) begin
                    n_rej = 1'b1;
                end else begin
                    n_cable[r_in_channel] = r_in_position;
                end
            end
            default: begin
                n_rej = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_out_pulses   <= '0;
            r_out_rej      <= 1'b0;
            r_jitter       <= JITTER_RESET;
            r_shb          <= '0;
            r_stg_shb      <= '0;
            r_staged_ready <= 1'b0;
            r_work         <= 1'b0;
            r_cmp          <= CMP_IDLE;
            for (int i = 0; i < NCH; i++) begin
                r_rem[i]       <= '0;
                r_ivl[i]       <= '0;
                r_due[i]       <= '0;
                r_stg_steps[i] <= '0;
                r_stg_ivl[i]   <= '0;
                r_cable[i]     <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                r_jitter <= i_cfg.data;
            end

            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end

            if (advance) begin
                r_rem          <= n_rem;
                r_shb          <= n_shb;
                r_ivl          <= n_ivl;
                r_due          <= n_due;
                r_stg_steps    <= n_stg_steps;
                r_stg_shb      <= n_stg_shb;
                r_stg_ivl      <= n_stg_ivl;
                r_staged_ready <= n_staged_ready;
                r_cable        <= n_cable;
                r_work         <= n_work;
                r_cmp          <= n_cmp;
                r_out_pulses   <= n_pulses;
                r_out_rej      <= n_rej;
                r_out_valid    <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the command payload on each input transaction.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_cmd      <= t_cmd'(i_in.cmd);
            r_in_channel  <= i_in.channel;
            r_in_steps    <= i_in.step_count;
            r_in_shorten  <= i_in.shorten;
            r_in_interval <= i_in.interval_us;
            r_in_position <= i_in.position;
            r_in_now      <= i_in.now_us;
        end
    end

    // ---------------------------------------------------------------- result port
    // Status and cable fields show the state left by the latest processed command.
    assign o_res.valid         = r_out_valid;
    assign o_res.step_pulses   = r_out_pulses;
    assign o_res.lengthen_dirs = ~r_shb;
    assign o_res.has_work      = r_work;
    assign o_res.batch_pending = r_staged_ready;
    assign o_res.compare_value = r_cmp;
    assign o_res.cable0        = r_cable[0];
    assign o_res.cable1        = r_cable[1];
    assign o_res.cable2        = r_cable[2];
    assign o_res.cable3        = r_cable[3];
    assign o_res.rejected      = r_out_rej;

    // ---------------------------------------------------------------- assertions
    a_pulse_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_in_cmd != CMD_TICK) |=> (r_out_pulses == '0))
        else $error("step pulse on a non-tick command");

    a_tick_never_rejects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_in_cmd == CMD_TICK) |=> !r_out_rej)
        else $error("tick flagged as rejected");

    a_work_after_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_in_cmd == CMD_TICK) |=> (r_work == (any_left || r_staged_ready)))
        else $error("work flag disagrees with remaining steps after tick");

    a_stage_while_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_staged_ready && (r_in_cmd == CMD_STAGE || r_in_cmd == CMD_PUBLISH)
        |=> r_out_rej && r_staged_ready)
        else $error("stage or publish accepted while a batch is pending");

endmodule
